/* design/ebpc_pkg.sv */
// Shared constants for the energy balance pitch controller.
package ebpc_pkg;
    localparam int unsigned ALT_W   = 32;
    localparam int unsigned DT_W    = 21;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CIDX_W  = 3;
    localparam logic [19:0] GRAVITY = 20'd642689;
    localparam logic [17:0] W_MAX   = 18'd131072;
    localparam logic [DT_W-1:0] MIN_STEP = 21'd2;

    localparam logic [CIDX_W-1:0] REG_TAU   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_SINK  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_CLIMB = 3'd2;
    localparam logic [CIDX_W-1:0] REG_W     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_ILIM  = 3'd4;
    localparam logic [CIDX_W-1:0] REG_DAMP  = 3'd5;
    localparam logic [CIDX_W-1:0] REG_PLO   = 3'd6;
    localparam logic [CIDX_W-1:0] REG_PHI   = 3'd7;
endpackage

/* design/energy_balance_pitch_controller.sv */
// Energy balance pitch loop: one shared multiplier and one serial divider under a sequencer.
//
// Input channel: i_valid / o_stall carries altitude target, measured altitude and
// time step. A beat is taken when i_valid is high and o_stall is low; o_stall is
// high from acceptance until the result beat has been taken.
// Output channel: o_valid / i_stall carries the pitch command, held while stalled.
// A time step under two LSB gives a zero command in the cycle after acceptance and
// leaves the state alone.
// Otherwise the bit-serial restoring divider runs in turn for the climb rate (skipped
// on the first item), the filter step, the rate setpoint and the pitch quotient
// (skipped when the pitch quotient saturates), with the shared multiplier used between
// them, and the pitch command is registered once the quotient is done.
// A new item is taken only after the result beat has been taken.
// Configuration writes via i_cfg_we / i_cfg_idx / i_cfg_data take effect at once; the user
// must make them only while the block is idle, as the block itself does not enforce it.
// Synchronous reset (i_rst_n low) restores the register defaults, clears the
// altitude history, filter and integral, and returns to idle.
module energy_balance_pitch_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [ebpc_pkg::ALT_W-1:0] i_altitude_target,
    input  logic signed [ebpc_pkg::ALT_W-1:0] i_altitude_measured,
    input  logic        [ebpc_pkg::DT_W-1:0]  i_time_step,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [ebpc_pkg::ALT_W-1:0] o_pitch_command,
    input  logic                             i_cfg_we,
    input  logic        [ebpc_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic        [ebpc_pkg::CFG_W-1:0]  i_cfg_data
);
    import ebpc_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RATE  = 5'd1;
    localparam logic [4:0] S_RATEW = 5'd2;
    localparam logic [4:0] S_FM    = 5'd3;
    localparam logic [4:0] S_FD    = 5'd4;
    localparam logic [4:0] S_FW    = 5'd5;
    localparam logic [4:0] S_RD    = 5'd6;
    localparam logic [4:0] S_RW    = 5'd7;
    localparam logic [4:0] S_K1    = 5'd8;
    localparam logic [4:0] S_K2    = 5'd9;
    localparam logic [4:0] S_ERR   = 5'd10;
    localparam logic [4:0] S_INT   = 5'd11;
    localparam logic [4:0] S_DH    = 5'd12;
    localparam logic [4:0] S_DL    = 5'd13;
    localparam logic [4:0] S_DEN   = 5'd14;
    localparam logic [4:0] S_PD    = 5'd15;
    localparam logic [4:0] S_PW    = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    logic [4:0]         r_state;
    logic [30:0]        r_tc, r_sink, r_climb, r_ilim, r_damp;
    logic [17:0]        r_w;
    logic signed [31:0] r_plo, r_phi;

    logic signed [31:0] r_tgt, r_meas, r_last, r_filt, r_integ, r_rate, r_rsp, r_pitch;
    logic [DT_W-1:0]    r_dt;
    logic               r_primed, r_sgn;
    logic signed [34:0] r_t1;
    logic signed [35:0] r_err;
    logic signed [53:0] r_ph, r_num;
    logic [61:0]        r_prod;

    logic [63:0]        r_dn, r_dq;
    logic [52:0]        r_dr;
    logic [50:0]        r_dd;
    logic [6:0]         r_dcnt;

    logic [30:0]        tau;
    logic [17:0]        w_c, k;
    logic [24:0]        dt10;
    logic signed [32:0] alt_d, sp_d, fr_d;
    logic [32:0]        alt_mag, sp_mag, fr_mag;
    logic [31:0]        rsp_mag, filt_mag;
    logic [35:0]        err_mag;
    logic [36:0]        mul_a;
    logic [24:0]        mul_b;
    logic [52:0]        div_rs;
    logic               div_ge;

    logic signed [53:0] rate_p, rate_v;
    logic signed [31:0] rate_sat;
    logic signed [34:0] dlt_p, dlt_v, fsum;
    logic signed [31:0] fsat;
    logic signed [49:0] rsp_p, rsp_v, rsp_lo, rsp_hi;
    logic signed [31:0] rsp_c;
    logic signed [34:0] t_p, t_v;
    logic signed [35:0] err_v;
    logic signed [36:0] x_p, x_v;
    logic signed [37:0] isum, ilo, ihi;
    logic signed [31:0] i_c;
    logic signed [53:0] ph_p, ph_v, pl_p, pl_v, num_v;
    logic [52:0]        num_mag;
    logic [50:0]        den;
    logic signed [33:0] pt_p, pt_v, plo_x, phi_x;
    logic signed [31:0] pt_c;

    always_comb begin
        tau     = (r_tc == 31'd0) ? 31'd1 : r_tc;
        w_c     = (r_w > W_MAX) ? W_MAX : r_w;
        k       = W_MAX - w_c;
        dt10    = 25'({r_dt, 3'b000}) + 25'({r_dt, 1'b0});
        alt_d   = {r_meas[31], r_meas} - {r_last[31], r_last};
        alt_mag = alt_d[32] ? 33'(-alt_d) : 33'(alt_d);
        sp_d    = {r_tgt[31], r_tgt} - {r_meas[31], r_meas};
        sp_mag  = sp_d[32] ? 33'(-sp_d) : 33'(sp_d);
        fr_d    = {r_rate[31], r_rate} - {r_filt[31], r_filt};
        fr_mag  = fr_d[32] ? 33'(-fr_d) : 33'(fr_d);
        rsp_mag = r_rsp[31] ? 32'(-r_rsp) : 32'(r_rsp);
        filt_mag = r_filt[31] ? 32'(-r_filt) : 32'(r_filt);
        err_mag = r_err[35] ? 36'(-r_err) : 36'(r_err);

        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_FM: begin
                mul_a = 37'(fr_mag);
                mul_b = dt10;
            end
            S_K1: begin
                mul_a = 37'(rsp_mag);
                mul_b = 25'(k);
            end
            S_K2: begin
                mul_a = 37'(filt_mag);
                mul_b = 25'(k);
            end
            S_INT: begin
                mul_a = 37'(err_mag);
                mul_b = 25'(r_dt);
            end
            S_DH: begin
                mul_a = {err_mag, 1'b0};
                mul_b = 25'(r_damp[30:16]);
            end
            S_DL: begin
                mul_a = {err_mag, 1'b0};
                mul_b = 25'(r_damp[15:0]);
            end
            S_DEN: begin
                mul_a = 37'(tau);
                mul_b = 25'(GRAVITY);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        div_rs = {r_dr[51:0], r_dn[63]};
        div_ge = div_rs >= {2'b00, r_dd};

        rate_p = $signed({1'b0, r_dq[52:0]});
        rate_v = r_sgn ? -rate_p : rate_p;
        if (rate_v < -54'sd2147483648) begin
            rate_sat = 32'sh8000_0000;
        end else if (rate_v > 54'sd2147483647) begin
            rate_sat = 32'sh7FFF_FFFF;
        end else begin
            rate_sat = rate_v[31:0];
        end

        dlt_p = $signed({1'b0, r_dq[33:0]});
        dlt_v = r_sgn ? -dlt_p : dlt_p;
        fsum  = {{3{r_filt[31]}}, r_filt} + dlt_v;
        if (fsum < -35'sd2147483648) begin
            fsat = 32'sh8000_0000;
        end else if (fsum > 35'sd2147483647) begin
            fsat = 32'sh7FFF_FFFF;
        end else begin
            fsat = fsum[31:0];
        end

        rsp_p  = $signed({1'b0, r_dq[48:0]});
        rsp_v  = r_sgn ? -rsp_p : rsp_p;
        rsp_hi = $signed({19'b0, r_climb});
        rsp_lo = -$signed({19'b0, r_sink});
        if (rsp_v < rsp_lo) begin
            rsp_c = rsp_lo[31:0];
        end else if (rsp_v > rsp_hi) begin
            rsp_c = rsp_hi[31:0];
        end else begin
            rsp_c = rsp_v[31:0];
        end

        t_p = $signed({2'b00, r_prod[48:16]});
        t_v = (r_state == S_K2) ? (r_rsp[31] ? -t_p : t_p) : (r_filt[31] ? -t_p : t_p);
        err_v = {r_t1[34], r_t1} - {t_v[34], t_v};

        x_p  = $signed({1'b0, r_prod[55:20]});
        x_v  = r_err[35] ? -x_p : x_p;
        isum = {{6{r_integ[31]}}, r_integ} + {x_v[36], x_v};
        ihi  = $signed({7'b0, r_ilim});
        ilo  = -ihi;
        if (isum < ilo) begin
            i_c = ilo[31:0];
        end else if (isum > ihi) begin
            i_c = ihi[31:0];
        end else begin
            i_c = isum[31:0];
        end

        ph_p  = $signed({2'b00, r_prod[51:0]});
        ph_v  = r_err[35] ? -ph_p : ph_p;
        pl_p  = $signed({16'b0, r_prod[53:16]});
        pl_v  = r_err[35] ? -pl_p : pl_p;
        num_v = r_ph + pl_v + {{22{r_integ[31]}}, r_integ};
        num_mag = r_num[53] ? 53'(-r_num) : 53'(r_num);
        den   = r_prod[50:0];

        pt_p  = $signed({1'b0, r_dq[32:0]});
        pt_v  = r_sgn ? -pt_p : pt_p;
        plo_x = {{2{r_plo[31]}}, r_plo};
        phi_x = {{2{r_phi[31]}}, r_phi};
        if (pt_v < plo_x) begin
            pt_c = r_plo;
        end else if (pt_v > phi_x) begin
            pt_c = r_phi;
        end else begin
            pt_c = pt_v[31:0];
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_pitch_command = r_pitch;

    always_ff @(posedge i_clk) begin
        r_prod <= 62'(mul_a * mul_b);
        if (r_dcnt != 7'd0) begin
            r_dn   <= {r_dn[62:0], 1'b0};
            r_dr   <= div_ge ? 53'(div_rs - {2'b00, r_dd}) : div_rs;
            r_dq   <= {r_dq[62:0], div_ge};
            r_dcnt <= r_dcnt - 7'd1;
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dcnt   <= '0;
            r_tc     <= 31'd327680;
            r_sink   <= 31'd327680;
            r_climb  <= 31'd327680;
            r_w      <= 18'd65536;
            r_ilim   <= 31'd65536;
            r_damp   <= 31'd6554;
            r_plo    <= -32'sd32768;
            r_phi    <= 32'sd32768;
            r_last   <= '0;
            r_filt   <= '0;
            r_integ  <= '0;
            r_primed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TAU:   r_tc    <= i_cfg_data[30:0];
                    REG_SINK:  r_sink  <= i_cfg_data[30:0];
                    REG_CLIMB: r_climb <= i_cfg_data[30:0];
                    REG_W:     r_w     <= i_cfg_data[17:0];
                    REG_ILIM:  r_ilim  <= i_cfg_data[30:0];
                    REG_DAMP:  r_damp  <= i_cfg_data[30:0];
                    REG_PLO:   r_plo   <= $signed(i_cfg_data);
                    REG_PHI:   r_phi   <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_tgt  <= i_altitude_target;
                        r_meas <= i_altitude_measured;
                        r_dt   <= i_time_step;
                        if (i_time_step < MIN_STEP) begin
                            r_pitch <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RATE;
                        end
                    end
                end
                S_RATE: begin
                    if (r_primed) begin
                        r_dn    <= 64'(alt_mag) << 31;
                        r_dr    <= '0;
                        r_dq    <= '0;
                        r_dd    <= 51'(r_dt);
                        r_dcnt  <= 7'd53;
                        r_sgn   <= alt_d[32];
                        r_state <= S_RATEW;
                    end else begin
                        r_rate  <= '0;
                        r_state <= S_FM;
                    end
                end
                S_RATEW: begin
                    if (r_dcnt == 7'd0) begin
                        r_rate  <= rate_sat;
                        r_state <= S_FM;
                    end
                end
                S_FM: r_state <= S_FD;
                S_FD: begin
                    r_dn    <= 64'(r_prod[56:0]) << 7;
                    r_dr    <= '0;
                    r_dq    <= '0;
                    r_dd    <= 51'({tau, 4'b0000}) + 51'(dt10);
                    r_dcnt  <= 7'd57;
                    r_sgn   <= fr_d[32];
                    r_state <= S_FW;
                end
                S_FW: begin
                    if (r_dcnt == 7'd0) begin
                        r_filt  <= fsat;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_dn    <= 64'(sp_mag) << 31;
                    r_dr    <= '0;
                    r_dq    <= '0;
                    r_dd    <= 51'(tau);
                    r_dcnt  <= 7'd49;
                    r_sgn   <= sp_d[32];
                    r_state <= S_RW;
                end
                S_RW: begin
                    if (r_dcnt == 7'd0) begin
                        r_rsp   <= rsp_c;
                        r_state <= S_K1;
                    end
                end
                S_K1: r_state <= S_K2;
                S_K2: begin
                    r_t1    <= t_v;
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_err   <= err_v;
                    r_state <= S_INT;
                end
                S_INT: r_state <= S_DH;
                S_DH: begin
                    r_integ <= i_c;
                    r_state <= S_DL;
                end
                S_DL: begin
                    r_ph    <= ph_v;
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    r_num   <= num_v;
                    r_state <= S_PD;
                end
                S_PD: begin
                    r_sgn   <= r_num[53];
                    r_dd    <= den;
                    r_dn    <= '0;
                    if ({1'b0, num_mag} >= {3'b000, den}) begin
                        r_dq   <= 64'h1_0000_0000;
                        r_dcnt <= '0;
                    end else begin
                        r_dr   <= num_mag;
                        r_dq   <= '0;
                        r_dcnt <= 7'd32;
                    end
                    r_state <= S_PW;
                end
                S_PW: begin
                    if (r_dcnt == 7'd0) begin
                        r_pitch  <= pt_c;
                        r_last   <= r_meas;
                        r_primed <= 1'b1;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
